// ===== src/acd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, register indexes and fixed-point constants of the anchor
// chaining score unit.
// ----------------------------------------------------------------------------
package acd_pkg;

	localparam int POS_W   = 31;
	localparam int SCORE_W = 31;
	localparam int CAP_W   = 8;
	localparam int WIN_W   = 7;
	localparam int CFG_W   = 8;
	localparam int IDX_W   = 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 31'h7FFF_FFFF;

	localparam logic [CAP_W-1:0] MATCH_CAP_RST = 8'd15;
	localparam logic [WIN_W-1:0] WINDOW_RST    = 7'd64;

	localparam logic [IDX_W-1:0] REG_MATCH_CAP     = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_IN_USE = 2'd1;

	// floor(n / 25) = (n * DIV25_MUL) >> DIV25_SHIFT, exact for n < 2^29
	localparam logic [29:0] DIV25_MUL   = 30'd687194768;
	localparam int          DIV25_SHIFT = 34;
	// same for n < 2^13
	localparam logic [13:0] DIV25_SMALL_MUL   = 14'd10486;
	localparam int          DIV25_SMALL_SHIFT = 18;

	// register stages inside one cell, anchor in to candidate out
	localparam int CELL_STAGES = 7;

	typedef struct packed {
		logic [POS_W-1:0]   ref_pos;
		logic [POS_W-1:0]   query_pos;
		logic [SCORE_W-1:0] score;
	} acd_entry_t;

	typedef struct packed {
		logic [POS_W-1:0] ref_pos;
		logic [POS_W-1:0] query_pos;
		logic [CAP_W-1:0] match_cap;
	} acd_anchor_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} acd_cell_ctrl_t;

	// levels of the radix-4 max tree
	function automatic int tree_levels(input int n);
		int lv;
		lv = 1;
		if (n > 1) begin
			lv = ($clog2(n) + 1) / 2;
		end
		return lv;
	endfunction

endpackage

// ===== src/acd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_cell
// One window slot: holds a predecessor anchor and its score, shifts to its
// neighbor on push, and scores the broadcast anchor against its entry.
// ----------------------------------------------------------------------------
module acd_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  acd_pkg::acd_cell_ctrl_t           ctrl,
	input  acd_pkg::acd_anchor_t              anchor,
	input  acd_pkg::acd_entry_t               prev_entry,
	input  logic                              prev_valid,
	input  logic                              in_span,
	output acd_pkg::acd_entry_t               entry,
	output logic                              valid,
	output logic [acd_pkg::SCORE_W-1:0]       cand
);

	acd_pkg::acd_entry_t entry_q;
	logic                valid_q;

	logic        ok_s1;
	logic [30:0] dx_s1;
	logic [30:0] dy_s1;
	logic [7:0]  alpha_s2;
	logic [30:0] gap_s2;
	logic [24:0] q1_s3;
	logic [6:0]  r1_s4;
	logic [32:0] kq_s4;
	logic [14:0] kr_s5;
	logic [7:0]  blo_s6;
	logic [30:0] cand_s7;

	logic [31:0] dx_full;
	logic [31:0] dy_full;
	logic [30:0] dmin;
	logic [58:0] q_prod;
	logic [30:0] hundred_q1;
	logic [30:0] rem_full;
	logic [26:0] b_prod;
	logic [34:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			entry_q <= prev_entry;
		end
	end

	assign dx_full = {1'b0, anchor.ref_pos} - {1'b0, entry_q.ref_pos};
	assign dy_full = {1'b0, anchor.query_pos} - {1'b0, entry_q.query_pos};
	assign dmin    = (dx_s1 < dy_s1) ? dx_s1 : dy_s1;

	// gap / 100 = (gap / 4) / 25
	assign q_prod     = {30'd0, gap_s2[30:2]} * {29'd0, acd_pkg::DIV25_MUL};
	assign hundred_q1 = {q1_s3, 6'd0} + {1'b0, q1_s3, 5'd0} + {4'd0, q1_s3, 2'd0};
	assign rem_full   = gap_s2 - hundred_q1;
	assign b_prod     = {14'd0, kr_s5[14:2]} * {13'd0, acd_pkg::DIV25_SMALL_MUL};

	// score + alpha - k*q1 - floor(k*r1/100)
	assign sum = {4'd0, entry_q.score} + {27'd0, alpha_s2} - {2'd0, kq_s4} - {27'd0, blo_s6};

	always_ff @(posedge clk) begin
		ok_s1    <= valid_q && in_span && (anchor.ref_pos > entry_q.ref_pos)
		            && (anchor.query_pos > entry_q.query_pos);
		dx_s1    <= dx_full[30:0];
		dy_s1    <= dy_full[30:0];

		alpha_s2 <= (dmin < 31'(anchor.match_cap)) ? dmin[7:0] : anchor.match_cap;
		gap_s2   <= (dy_s1 >= dx_s1) ? (dy_s1 - dx_s1) : (dx_s1 - dy_s1);

		q1_s3    <= q_prod[acd_pkg::DIV25_SHIFT+24:acd_pkg::DIV25_SHIFT];

		r1_s4    <= rem_full[6:0];
		kq_s4    <= {25'd0, anchor.match_cap} * {8'd0, q1_s3};

		kr_s5    <= {7'd0, anchor.match_cap} * {8'd0, r1_s4};

		blo_s6   <= b_prod[acd_pkg::DIV25_SMALL_SHIFT+7:acd_pkg::DIV25_SMALL_SHIFT];

		if (!ok_s1 || sum[34]) begin
			cand_s7 <= '0;
		end else if (|sum[33:31]) begin
			cand_s7 <= acd_pkg::SCORE_MAX;
		end else begin
			cand_s7 <= sum[30:0];
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign cand  = cand_s7;

endmodule

// ===== src/acd_max_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acd_max_tree
// Registered radix-4 maximum over the cell candidates, with a register at every tree level.
// ----------------------------------------------------------------------------
module acd_max_tree #(
	parameter int N = 64
) (
	input  logic                        clk,
	input  logic [acd_pkg::SCORE_W-1:0] leaf [N],
	output logic [acd_pkg::SCORE_W-1:0] root
);

	localparam int L = acd_pkg::tree_levels(N);
	localparam int P = 4 ** L;
	localparam int I = (P - 1) / 3;

	logic [acd_pkg::SCORE_W-1:0] node_q [I];

	function automatic logic [acd_pkg::SCORE_W-1:0] max4(
		input logic [acd_pkg::SCORE_W-1:0] a,
		input logic [acd_pkg::SCORE_W-1:0] b,
		input logic [acd_pkg::SCORE_W-1:0] c,
		input logic [acd_pkg::SCORE_W-1:0] d
	);
		logic [acd_pkg::SCORE_W-1:0] ab;
		logic [acd_pkg::SCORE_W-1:0] cd;
		ab = (a > b) ? a : b;
		cd = (c > d) ? c : d;
		return (ab > cd) ? ab : cd;
	endfunction

	for (genvar n = 0; n < I; n++) begin : g_node
		logic [acd_pkg::SCORE_W-1:0] kid [4];
		for (genvar j = 0; j < 4; j++) begin : g_kid
			localparam int C = 4 * n + 1 + j;
			if (C < I) begin : g_inner
				assign kid[j] = node_q[C];
			end else if (C - I < N) begin : g_leaf
				assign kid[j] = leaf[C - I];
			end else begin : g_pad
				assign kid[j] = '0;
			end
		end
		always_ff @(posedge clk) begin
			node_q[n] <= max4(kid[0], kid[1], kid[2], kid[3]);
		end
	end

	assign root = node_q[0];

endmodule

// ===== src/anchor_chaining_dp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_chaining_dp_core
// Chaining score unit: scores each anchor against a shifting window of
// predecessor anchors held in a row of cells, then pushes it into the window.
//
//   channel  direction  handshake            payload
//   in       to core    in_valid / in_ready  ref_pos, query_pos, first_of_chain
//   out      from core  out_valid/out_ready  chain_score
//   cfg      to core    cfg_wr_en            cfg_index, cfg_wdata
//
// One anchor at a time: in_ready is high only while idle. Each anchor is
// loaded, runs the seven cell stages and the max tree levels, then is pushed.
// The next anchor needs this anchor's score in window slot 0.
// Reset clears the slot valid bits, state, config and out_valid; no clearing pass.
// A result held on out waits; the core finishes only when out is free.
// ----------------------------------------------------------------------------
module anchor_chaining_dp_core #(
	parameter int LOOKBACK_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [acd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [acd_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [acd_pkg::POS_W-1:0]   ref_pos,
	input  logic [acd_pkg::POS_W-1:0]   query_pos,
	input  logic                        first_of_chain,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [acd_pkg::SCORE_W-1:0] chain_score
);

	localparam int LEVELS  = acd_pkg::tree_levels(LOOKBACK_DEPTH);
	localparam int LATENCY = acd_pkg::CELL_STAGES + LEVELS;
	localparam int CNT_W   = $clog2(LATENCY + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [acd_pkg::CAP_W-1:0]    match_cap_q;
	logic [acd_pkg::WIN_W-1:0]    window_in_use_q;
	logic [acd_pkg::POS_W-1:0]    ref_q;
	logic [acd_pkg::POS_W-1:0]    qry_q;
	logic [acd_pkg::SCORE_W-1:0]  score_q;
	logic                         out_valid_q;

	logic                         accept;
	logic                         out_free;
	logic                         finish;
	logic [acd_pkg::SCORE_W-1:0]  tree_root;
	logic [acd_pkg::SCORE_W-1:0]  best;

	acd_pkg::acd_cell_ctrl_t      cell_ctrl;
	acd_pkg::acd_anchor_t         bcast;
	acd_pkg::acd_entry_t          head;
	acd_pkg::acd_entry_t          cell_entry [LOOKBACK_DEPTH];
	logic [LOOKBACK_DEPTH-1:0]    cell_valid;
	logic [acd_pkg::SCORE_W-1:0]  cand [LOOKBACK_DEPTH];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_BUSY) && (cnt_q == '0) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_cap_q     <= acd_pkg::MATCH_CAP_RST;
			window_in_use_q <= acd_pkg::WINDOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				acd_pkg::REG_MATCH_CAP: begin
					match_cap_q <= cfg_wdata;
				end
				acd_pkg::REG_WINDOW_IN_USE: begin
					window_in_use_q <= cfg_wdata[acd_pkg::WIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
						cnt_q   <= CNT_W'(LATENCY);
					end
				end
				ST_BUSY: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_q <= ref_pos;
			qry_q <= query_pos;
		end
		if (finish) begin
			score_q <= best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign best = (tree_root > 31'(match_cap_q)) ? tree_root : 31'(match_cap_q);

	assign cell_ctrl.shift = finish;
	assign cell_ctrl.clear = accept && first_of_chain;

	assign bcast.ref_pos   = ref_q;
	assign bcast.query_pos = qry_q;
	assign bcast.match_cap = match_cap_q;

	assign head.ref_pos   = ref_q;
	assign head.query_pos = qry_q;
	assign head.score     = best;

	for (genvar g = 0; g < LOOKBACK_DEPTH; g++) begin : g_cell
		acd_pkg::acd_entry_t prev_e;
		logic                prev_v;
		logic                in_span;
		if (g == 0) begin : g_head
			assign prev_e = head;
			assign prev_v = 1'b1;
		end else begin : g_link
			assign prev_e = cell_entry[g-1];
			assign prev_v = cell_valid[g-1];
		end
		assign in_span = 32'(g) < 32'(window_in_use_q);
		acd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.anchor     (bcast),
			.prev_entry (prev_e),
			.prev_valid (prev_v),
			.in_span    (in_span),
			.entry      (cell_entry[g]),
			.valid      (cell_valid[g]),
			.cand       (cand[g])
		);
	end

	acd_max_tree #(
		.N (LOOKBACK_DEPTH)
	) u_tree (
		.clk  (clk),
		.leaf (cand),
		.root (tree_root)
	);

	assign out_valid   = out_valid_q;
	assign chain_score = score_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_BUSY) && !in_ready)
		else $error("core not busy after accepting an anchor");

	a_clear_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && first_of_chain |=> (cell_valid == '0))
		else $error("window not emptied on first_of_chain");

	a_push_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> cell_valid[0])
		else $error("finished anchor not pushed into slot 0");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("latency counter running while idle");

endmodule
